@@ sv/rrts_pkg.sv @@
// ---------------------------------------------------------------------------
// rrts_pkg: shared types and codes of the round-robin thread scheduler
// Request and result layouts, opcodes, status codes and thread states.
// ---------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int MAX_THREADS_DEF = 128;
  localparam logic [19:0] QLEN_RESET = 20'd1000;
  localparam int APB_AW = 2;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_SPAWN  = 3'd1;
  localparam logic [2:0] OP_TERM   = 3'd2;
  localparam logic [2:0] OP_BLOCK  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;
  localparam logic [2:0] OP_LOCK   = 3'd5;
  localparam logic [2:0] OP_UNLOCK = 3'd6;
  localparam logic [2:0] OP_QUERY  = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_TID  = 3'd1;
  localparam logic [2:0] ST_HOLDS    = 3'd2;
  localparam logic [2:0] ST_UNLOCKED = 3'd3;
  localparam logic [2:0] ST_OTHER    = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_NO_READY = 3'd6;

  localparam logic [2:0] TS_EMPTY     = 3'd0;
  localparam logic [2:0] TS_READY     = 3'd1;
  localparam logic [2:0] TS_BLOCKED   = 3'd2;
  localparam logic [2:0] TS_RUNNING   = 3'd3;
  localparam logic [2:0] TS_MXBLOCKED = 3'd4;
  localparam logic [2:0] TS_DBLOCKED  = 3'd5;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic [6:0]  running_id;
    logic [31:0] total_quanta;
    logic        switched;
  } rsp_t;

  // thread table word: lock retry flag and thread state
  typedef struct packed {
    logic       pend;
    logic [2:0] state;
  } tsw_t;

  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } qctl_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cellctl_t;

endpackage

`default_nettype wire

@@ sv/rrts_ram.sv @@
// ---------------------------------------------------------------------------
// rrts_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/rrts_qcell.sv @@
// ---------------------------------------------------------------------------
// rrts_qcell: one cell of a shifting queue
// Holds one entry; loads a pushed entry or takes its neighbor's on a pop.
// ---------------------------------------------------------------------------
`default_nettype none

module rrts_qcell
  import rrts_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire cellctl_t         ctl,
  input  wire logic [WIDTH-1:0] nbr,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= din;
    end else if (ctl.shift) begin
      q <= nbr;
    end
  end

endmodule

`default_nettype wire

@@ sv/rrts_queue.sv @@
// ---------------------------------------------------------------------------
// rrts_queue: FIFO built as a row of shifting cells
// Head sits in cell 0; a pop shifts every cell toward the head together.
// ---------------------------------------------------------------------------
`default_nettype none

module rrts_queue
  import rrts_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire qctl_t                      ctl,
  input  wire logic [WIDTH-1:0]           din,
  output logic      [WIDTH-1:0]           head,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] vals [DEPTH];
  logic [CW-1:0]    wr_idx;

  assign wr_idx = count - CW'(ctl.pop);
  assign head   = vals[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cellctl_t         cc;
    logic [WIDTH-1:0] nbr;
    assign cc.shift = ctl.pop;
    assign cc.load  = ctl.push && (wr_idx == CW'(i));
    if (i < DEPTH - 1) begin : g_mid
      assign nbr = vals[i+1];
    end else begin : g_last
      assign nbr = '0;
    end
    rrts_qcell #(.WIDTH(WIDTH)) u_cell (
      .clk (clk),
      .ctl (cc),
      .nbr (nbr),
      .din (din),
      .q   (vals[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      count <= '0;
    end else begin
      count <= count + CW'(ctl.push) - CW'(ctl.pop);
    end
  end

endmodule

`default_nettype wire

@@ sv/round_robin_thread_scheduler.sv @@
// ---------------------------------------------------------------------------
// round_robin_thread_scheduler: hardware round-robin thread scheduler
// Per-thread states, ready and mutex-waiter queues, quantum countdown.
// ---------------------------------------------------------------------------
// Usage:
//   req (opcode, thread_id) enters on req_valid/req_ready; each transaction
//   yields exactly one rsp transaction on rsp_valid/rsp_ready.
//   quantum_length sits at APB address 0; write it only while idle.
//   Flow: an accepted request passes S_RD and S_DONE, rsp_valid is
//   registered from S_DONE, and the next request is taken back in S_IDLE.
//   A dispatch or a wake-up pops queue entries one at a time through
//   S_DISP/S_DISP2 or S_WAKE/S_WAKE2, since RAM read data is registered;
//   removing a thread from a queue rotates each queued entry through S_REM;
//   a spawn scans the thread table slot by slot through S_SCAN/S_SCAN2.
//   One request is worked at a time; req_ready is high whenever the
//   sequencer is idle, even while a result waits in the output register.
//   Reset (and terminating thread 0) makes thread 0 running, all other
//   slots empty, the queues empty and the mutex free, at once.
//   A stalled receiver holds the result; the next result waits in the
//   sequencer until the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module round_robin_thread_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_THREADS = MAX_THREADS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output rsp_t                   rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int AW = $clog2(MAX_THREADS);
  localparam int CW = $clog2(MAX_THREADS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_DISP2 = 4'd3;
  localparam logic [3:0] S_WAKE  = 4'd4;
  localparam logic [3:0] S_WAKE2 = 4'd5;
  localparam logic [3:0] S_REM   = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_SCAN2 = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // control registers
  logic [3:0]  st, st_next;
  logic        busy, busy_next;
  logic [AW-1:0] owner, owner_next;
  logic [AW-1:0] cur, cur_next;
  logic [31:0] total, total_next;
  logic [CW-1:0] live, live_next;
  logic [19:0] ticks, ticks_next;
  logic [19:0] qlen;
  logic [CW-1:0] npend, npend_next;
  logic        wake_after, wake_after_next;
  logic        rem_rq, rem_rq_next;
  logic [CW-1:0] rem_n, rem_n_next;
  logic [MAX_THREADS-1:0] tvalid, qvalid;
  logic        clear_all;

  // request and working registers
  logic [2:0]  op, op_next;
  logic [6:0]  tid, tid_next;
  logic        tok, tok_next;
  logic [AW-1:0] t_a, t_a_next;
  logic [AW-1:0] hd, hd_next;
  logic        hd_p, hd_p_next;
  logic [AW-1:0] scan_i, scan_i_next;
  logic [2:0]  res_status, res_status_next;
  logic [31:0] res_value, res_value_next;
  logic        res_sw, res_sw_next;

  // RAM ports
  logic          ts_we, qc_we;
  logic [AW-1:0] ts_waddr, qc_waddr, ts_raddr, qc_raddr, ts_ra_q, qc_ra_q;
  tsw_t          ts_wdata, ts_rdata, ts_word;
  logic [31:0]   qc_wdata, qc_rdata, qc_word;

  // queues
  qctl_t         rq_ctl, wq_ctl;
  logic [AW:0]   rq_din, rq_head;
  logic [AW-1:0] wq_din, wq_head;
  logic [CW-1:0] rq_count, wq_count;

  logic          in_tid_ok;
  logic [AW-1:0] in_addr;
  logic [19:0]   load_ticks;
  logic          cd_base, owns, cd_term;

  assign in_tid_ok  = 32'(req.thread_id) < MAX_THREADS;
  assign in_addr    = in_tid_ok ? AW'(req.thread_id) : '0;
  assign load_ticks = (qlen == 20'd0) ? 20'd1 : qlen;

  assign ts_word = tvalid[ts_ra_q] ? ts_rdata
                 : ((ts_ra_q == '0) ? tsw_t'{1'b0, TS_RUNNING} : tsw_t'{1'b0, TS_EMPTY});
  assign qc_word = qvalid[qc_ra_q] ? qc_rdata : ((qc_ra_q == '0) ? 32'd1 : 32'd0);

  assign cd_base = (rq_count != '0) && (!busy || (rq_count > npend));
  assign owns    = busy && (owner == t_a);
  assign cd_term = (rq_count != '0) && (!(busy && !owns) || (rq_count > npend));

  assign req_ready = (st == S_IDLE);
  assign pready    = 1'b1;
  assign prdata    = {12'd0, qlen};

  always_comb begin
    st_next         = st;
    busy_next       = busy;
    owner_next      = owner;
    cur_next        = cur;
    total_next      = total;
    live_next       = live;
    ticks_next      = ticks;
    npend_next      = npend;
    wake_after_next = wake_after;
    rem_rq_next     = rem_rq;
    rem_n_next      = rem_n;
    op_next         = op;
    tid_next        = tid;
    tok_next        = tok;
    t_a_next        = t_a;
    hd_next         = hd;
    hd_p_next       = hd_p;
    scan_i_next     = scan_i;
    res_status_next = res_status;
    res_value_next  = res_value;
    res_sw_next     = res_sw;
    clear_all       = 1'b0;
    ts_we = 1'b0; ts_waddr = t_a; ts_wdata = tsw_t'{1'b0, TS_EMPTY};
    qc_we = 1'b0; qc_waddr = hd;  qc_wdata = '0;
    ts_raddr = '0;
    qc_raddr = '0;
    rq_ctl = '0; rq_din = '0;
    wq_ctl = '0; wq_din = '0;

    unique case (st)
      S_IDLE: begin
        ts_raddr = in_addr;
        qc_raddr = in_addr;
        if (req_valid) begin
          op_next         = req.opcode;
          tid_next        = req.thread_id;
          tok_next        = in_tid_ok;
          t_a_next        = in_addr;
          res_status_next = ST_OK;
          res_value_next  = '0;
          res_sw_next     = 1'b0;
          wake_after_next = 1'b0;
          st_next         = S_RD;
        end
      end

      S_RD: begin
        st_next = S_DONE;
        unique case (op)
          OP_TICK: begin
            if (ticks > 20'd1) begin
              ticks_next = ticks - 20'd1;
            end else begin
              ts_we = 1'b1; ts_waddr = cur; ts_wdata = tsw_t'{1'b0, TS_READY};
              rq_ctl.push = 1'b1; rq_din = {cur, 1'b0};
              res_sw_next = 1'b1;
              st_next     = S_DISP;
            end
          end
          OP_SPAWN: begin
            if (32'(live) >= MAX_THREADS) begin
              res_status_next = ST_FULL;
            end else begin
              scan_i_next = '0;
              st_next     = S_SCAN;
            end
          end
          OP_TERM: begin
            if (tok && ts_word.state != TS_EMPTY && tid == 7'd0) begin
              // full restart of the scheduler state
              clear_all   = 1'b1;
              rq_ctl.clr  = 1'b1;
              wq_ctl.clr  = 1'b1;
              busy_next   = 1'b0;
              owner_next  = '0;
              cur_next    = '0;
              total_next  = 32'd1;
              live_next   = CW'(1);
              ticks_next  = load_ticks;
              npend_next  = '0;
            end else if (!tok || ts_word.state == TS_EMPTY) begin
              res_status_next = ST_BAD_TID;
            end else if (ts_word.state == TS_RUNNING) begin
              if (!cd_term) begin
                res_status_next = ST_NO_READY;
              end else begin
                ts_we = 1'b1; ts_wdata = tsw_t'{1'b0, TS_EMPTY};
                live_next       = live - CW'(1);
                busy_next       = busy && !owns;
                wake_after_next = owns;
                res_sw_next     = 1'b1;
                st_next         = S_DISP;
              end
            end else begin
              ts_we = 1'b1; ts_wdata = tsw_t'{1'b0, TS_EMPTY};
              live_next       = live - CW'(1);
              busy_next       = busy && !owns;
              wake_after_next = owns;
              rem_rq_next     = (ts_word.state == TS_READY);
              rem_n_next      = (ts_word.state == TS_READY) ? rq_count : wq_count;
              st_next         = S_REM;
            end
          end
          OP_BLOCK: begin
            if (!tok || ts_word.state == TS_EMPTY || tid == 7'd0) begin
              res_status_next = ST_BAD_TID;
            end else if (ts_word.state == TS_RUNNING) begin
              if (!cd_base) begin
                res_status_next = ST_NO_READY;
              end else begin
                ts_we = 1'b1; ts_wdata = tsw_t'{ts_word.pend, TS_BLOCKED};
                res_sw_next = 1'b1;
                st_next     = S_DISP;
              end
            end else if (ts_word.state == TS_READY) begin
              ts_we = 1'b1; ts_wdata = tsw_t'{ts_word.pend, TS_BLOCKED};
              rem_rq_next = 1'b1;
              rem_n_next  = rq_count;
              st_next     = S_REM;
            end else if (ts_word.state == TS_MXBLOCKED) begin
              ts_we = 1'b1; ts_wdata = tsw_t'{ts_word.pend, TS_DBLOCKED};
            end
          end
          OP_RESUME: begin
            if (!tok || ts_word.state == TS_EMPTY || tid == 7'd0) begin
              res_status_next = ST_BAD_TID;
            end else if (ts_word.state == TS_BLOCKED) begin
              ts_we = 1'b1; ts_wdata = tsw_t'{ts_word.pend, TS_READY};
              rq_ctl.push = 1'b1; rq_din = {t_a, ts_word.pend};
              npend_next  = npend + CW'(ts_word.pend);
            end else if (ts_word.state == TS_DBLOCKED) begin
              ts_we = 1'b1; ts_wdata = tsw_t'{ts_word.pend, TS_MXBLOCKED};
            end
          end
          OP_LOCK: begin
            if (!busy) begin
              busy_next  = 1'b1;
              owner_next = cur;
            end else if (owner == cur) begin
              res_status_next = ST_HOLDS;
            end else if (!cd_base) begin
              res_status_next = ST_NO_READY;
            end else begin
              ts_we = 1'b1; ts_waddr = cur; ts_wdata = tsw_t'{1'b1, TS_MXBLOCKED};
              wq_ctl.push = 1'b1; wq_din = cur;
              res_sw_next = 1'b1;
              st_next     = S_DISP;
            end
          end
          OP_UNLOCK: begin
            if (!busy) begin
              res_status_next = ST_UNLOCKED;
            end else if (owner != cur) begin
              res_status_next = ST_OTHER;
            end else begin
              busy_next = 1'b0;
              st_next   = S_WAKE;
            end
          end
          default: begin
            if (!tok || ts_word.state == TS_EMPTY) begin
              res_status_next = ST_BAD_TID;
            end else begin
              res_value_next = qc_word;
            end
          end
        endcase
      end

      S_DISP: begin
        if (rq_count == '0) begin
          st_next = wake_after ? S_WAKE : S_DONE;
        end else begin
          rq_ctl.pop = 1'b1;
          hd_next    = rq_head[AW:1];
          hd_p_next  = rq_head[0];
          qc_raddr   = rq_head[AW:1];
          total_next = total + 32'd1;
          npend_next = npend - CW'(rq_head[0]);
          st_next    = S_DISP2;
        end
      end

      S_DISP2: begin
        qc_we = 1'b1; qc_waddr = hd; qc_wdata = qc_word + 32'd1;
        ts_waddr = hd;
        if (hd_p && busy) begin
          // retry fails: back to the waiter queue
          ts_we = 1'b1; ts_wdata = tsw_t'{1'b1, TS_MXBLOCKED};
          wq_ctl.push = 1'b1; wq_din = hd;
          st_next = S_DISP;
        end else begin
          if (hd_p) begin
            busy_next  = 1'b1;
            owner_next = hd;
          end
          ts_we = 1'b1; ts_wdata = tsw_t'{1'b0, TS_RUNNING};
          cur_next   = hd;
          ticks_next = load_ticks;
          st_next    = wake_after ? S_WAKE : S_DONE;
        end
      end

      S_WAKE: begin
        if (wq_count == '0) begin
          st_next = S_DONE;
        end else begin
          wq_ctl.pop = 1'b1;
          hd_next    = wq_head;
          ts_raddr   = wq_head;
          st_next    = S_WAKE2;
        end
      end

      S_WAKE2: begin
        ts_waddr = hd;
        if (ts_word.state == TS_DBLOCKED) begin
          ts_we = 1'b1; ts_wdata = tsw_t'{ts_word.pend, TS_BLOCKED};
          st_next = S_DONE;
        end else if (ts_word.state == TS_MXBLOCKED) begin
          ts_we = 1'b1; ts_wdata = tsw_t'{ts_word.pend, TS_READY};
          rq_ctl.push = 1'b1; rq_din = {hd, ts_word.pend};
          npend_next  = npend + CW'(ts_word.pend);
          st_next     = S_DONE;
        end else begin
          // stale entry: skip it
          st_next = S_WAKE;
        end
      end

      S_REM: begin
        // rotate the queue once, dropping the target thread
        if (rem_n == '0) begin
          st_next = wake_after ? S_WAKE : S_DONE;
        end else begin
          rem_n_next = rem_n - CW'(1);
          if (rem_rq) begin
            rq_ctl.pop = 1'b1;
            rq_din     = rq_head;
            if (rq_head[AW:1] != t_a) begin
              rq_ctl.push = 1'b1;
            end else begin
              npend_next = npend - CW'(rq_head[0]);
            end
          end else begin
            wq_ctl.pop  = 1'b1;
            wq_din      = wq_head;
            wq_ctl.push = (wq_head != t_a);
          end
        end
      end

      S_SCAN: begin
        ts_raddr = scan_i;
        st_next  = S_SCAN2;
      end

      S_SCAN2: begin
        if (ts_word.state == TS_EMPTY) begin
          ts_we = 1'b1; ts_waddr = scan_i; ts_wdata = tsw_t'{1'b0, TS_READY};
          qc_we = 1'b1; qc_waddr = scan_i; qc_wdata = '0;
          rq_ctl.push    = 1'b1; rq_din = {scan_i, 1'b0};
          live_next      = live + CW'(1);
          res_value_next = 32'(scan_i);
          st_next        = S_DONE;
        end else if (32'(scan_i) == MAX_THREADS - 1) begin
          res_status_next = ST_FULL;
          st_next         = S_DONE;
        end else begin
          scan_i_next = scan_i + AW'(1);
          st_next     = S_SCAN;
        end
      end

      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          st_next = S_IDLE;
        end
      end

      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      busy       <= 1'b0;
      owner      <= '0;
      cur        <= '0;
      total      <= 32'd1;
      live       <= CW'(1);
      ticks      <= QLEN_RESET;
      qlen       <= QLEN_RESET;
      npend      <= '0;
      wake_after <= 1'b0;
      rem_rq     <= 1'b0;
      rem_n      <= '0;
      tvalid     <= '0;
      qvalid     <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      st         <= st_next;
      busy       <= busy_next;
      owner      <= owner_next;
      cur        <= cur_next;
      total      <= total_next;
      live       <= live_next;
      ticks      <= ticks_next;
      npend      <= npend_next;
      wake_after <= wake_after_next;
      rem_rq     <= rem_rq_next;
      rem_n      <= rem_n_next;
      if (psel && penable && pwrite) begin
        qlen <= pwdata[19:0];
      end
      if (clear_all) begin
        tvalid <= '0;
        qvalid <= '0;
      end else begin
        if (ts_we) tvalid[ts_waddr] <= 1'b1;
        if (qc_we) qvalid[qc_waddr] <= 1'b1;
      end
      if (st == S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    tid        <= tid_next;
    tok        <= tok_next;
    t_a        <= t_a_next;
    hd         <= hd_next;
    hd_p       <= hd_p_next;
    scan_i     <= scan_i_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    res_sw     <= res_sw_next;
    ts_ra_q    <= ts_raddr;
    qc_ra_q    <= qc_raddr;
    if (st == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp.status       <= res_status;
      rsp.value        <= res_value;
      rsp.running_id   <= 7'(cur);
      rsp.total_quanta <= total;
      rsp.switched     <= res_sw;
    end
  end

  rrts_ram #(.WIDTH(4), .DEPTH(MAX_THREADS)) u_tstate (
    .clk   (clk),
    .we    (ts_we),
    .waddr (ts_waddr),
    .wdata (ts_wdata),
    .raddr (ts_raddr),
    .rdata (ts_rdata)
  );

  rrts_ram #(.WIDTH(32), .DEPTH(MAX_THREADS)) u_qcount (
    .clk   (clk),
    .we    (qc_we),
    .waddr (qc_waddr),
    .wdata (qc_wdata),
    .raddr (qc_raddr),
    .rdata (qc_rdata)
  );

  rrts_queue #(.WIDTH(AW + 1), .DEPTH(MAX_THREADS)) u_ready_q (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rq_ctl),
    .din   (rq_din),
    .head  (rq_head),
    .count (rq_count)
  );

  rrts_queue #(.WIDTH(AW), .DEPTH(MAX_THREADS)) u_waiter_q (
    .clk   (clk),
    .rst   (rst),
    .ctl   (wq_ctl),
    .din   (wq_din),
    .head  (wq_head),
    .count (wq_count)
  );

  a_npend_bound: assert property (@(posedge clk) disable iff (rst)
    npend <= rq_count)
    else $error("pending-lock count exceeds ready queue depth");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    (live != '0) && (32'(live) <= MAX_THREADS))
    else $error("live thread count out of range");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (st == S_RD))
    else $error("accepted transaction not decoded");

  a_disp_pop: assert property (@(posedge clk) disable iff (rst)
    (st == S_DISP && rq_count != '0) |=> (st == S_DISP2))
    else $error("dispatch pop not followed by update");

endmodule

`default_nettype wire
